// ===== hdl/msp_pkg.sv =====
`timescale 1ns / 1ps

package msp_pkg;

    // Sizes and protocol constants
    localparam int BUFFER_BYTES = 32;
    localparam int FRAME_LEN    = 13;
    localparam int CRC_SPAN     = 11;
    localparam int REQ_LEN      = 8;
    localparam int REQ_CRC_SPAN = 6;

    localparam logic [15:0] TIMEOUT_RESET     = 16'd100;
    localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  START_REG_HI      = 8'h00;
    localparam logic [7:0]  START_REG_LO      = 8'h00;
    localparam logic [7:0]  REG_COUNT_HI      = 8'h00;
    localparam logic [7:0]  REG_COUNT_LO      = 8'h04;
    localparam logic [7:0]  RESP_BYTE_COUNT   = 8'h08;

    // Input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result kinds and failure causes
    localparam logic [1:0] RK_TX      = 2'd0;
    localparam logic [1:0] RK_READING = 2'd1;
    localparam logic [1:0] RK_FAIL    = 2'd2;
    localparam logic       CAUSE_TIMEOUT = 1'b0;
    localparam logic       CAUSE_FULL    = 1'b1;

    // Byte positions within a response window
    localparam logic [3:0] WIN_ADDR     = 4'd0;
    localparam logic [3:0] WIN_FUNC     = 4'd1;
    localparam logic [3:0] WIN_COUNT    = 4'd2;
    localparam logic [3:0] WIN_LEVEL_HI = 4'd3;
    localparam logic [3:0] WIN_LEVEL_LO = 4'd4;
    localparam logic [3:0] WIN_TEMP_HI  = 4'd9;
    localparam logic [3:0] WIN_TEMP_LO  = 4'd10;
    localparam logic [3:0] WIN_CRC_LO   = 4'd11;
    localparam logic [3:0] WIN_CRC_HI   = 4'd12;

    // Request byte positions
    localparam logic [2:0] REQ_ADDR   = 3'd0;
    localparam logic [2:0] REQ_FUNC   = 3'd1;
    localparam logic [2:0] REQ_REG_HI = 3'd2;
    localparam logic [2:0] REQ_REG_LO = 3'd3;
    localparam logic [2:0] REQ_CNT_HI = 3'd4;
    localparam logic [2:0] REQ_CNT_LO = 3'd5;
    localparam logic [2:0] REQ_CRC_LO = 3'd6;
    localparam logic [2:0] REQ_CRC_HI = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sensor_id;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [7:0]         tx_byte;
        logic [15:0]        water_level;
        logic signed [15:0] temperature;
        logic               fail_cause;
        logic               last;
    } out_item_t;

    // Microcode
    typedef logic [3:0] step_t;

    localparam step_t STEP_ACCEPT  = 4'd0;
    localparam step_t STEP_S_INIT  = 4'd1;
    localparam step_t STEP_S_REQ   = 4'd2;
    localparam step_t STEP_S_DONE  = 4'd3;
    localparam step_t STEP_T_INC   = 4'd4;
    localparam step_t STEP_T_CHK   = 4'd5;
    localparam step_t STEP_T_FAIL  = 4'd6;
    localparam step_t STEP_B_STORE = 4'd7;
    localparam step_t STEP_B_INIT  = 4'd8;
    localparam step_t STEP_B_ADV   = 4'd9;
    localparam step_t STEP_B_SCAN  = 4'd10;
    localparam step_t STEP_B_CHK   = 4'd11;
    localparam step_t STEP_B_FULL  = 4'd12;
    localparam step_t STEP_B_OVF   = 4'd13;
    localparam step_t STEP_B_HIT   = 4'd14;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_START,
        OP_REQ,
        OP_TICK,
        OP_STORE,
        OP_SCAN_INIT,
        OP_SCAN_ADV,
        OP_SCAN,
        OP_CLOSE
    } dp_op_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_TX,
        EMIT_READING,
        EMIT_FAIL_TIME,
        EMIT_FAIL_FULL
    } emit_t;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DISPATCH,
        COND_REQ_MORE,
        COND_SCAN_MORE,
        COND_NO_WINDOW,
        COND_MATCH,
        COND_NOT_FULL,
        COND_NOT_TIMEOUT
    } cond_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
        emit_t  emit;
        cond_t  cond;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_kind;
        logic       active;
        logic       req_more;
        logic       scan_more;
        logic       window;
        logic       match;
        logic       full;
        logic       timeout;
        logic       out_free;
    } flags_t;

    // The control store. A step jumps to its target when its condition holds and
    // otherwise falls through to the next step; the accept step dispatches instead.
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        begin
            unique case (step)
                STEP_ACCEPT:  w = '{1'b1, OP_LATCH, EMIT_NONE, COND_DISPATCH, STEP_ACCEPT};
                STEP_S_INIT:  w = '{1'b0, OP_START, EMIT_NONE, COND_NEXT, STEP_ACCEPT};
                STEP_S_REQ:   w = '{1'b0, OP_REQ, EMIT_TX, COND_REQ_MORE, STEP_S_REQ};
                STEP_S_DONE:  w = '{1'b0, OP_NONE, EMIT_NONE, COND_JUMP, STEP_ACCEPT};
                STEP_T_INC:   w = '{1'b0, OP_TICK, EMIT_NONE, COND_NEXT, STEP_ACCEPT};
                STEP_T_CHK:   w = '{1'b0, OP_NONE, EMIT_NONE, COND_NOT_TIMEOUT, STEP_ACCEPT};
                STEP_T_FAIL:  w = '{1'b0, OP_CLOSE, EMIT_FAIL_TIME, COND_JUMP, STEP_ACCEPT};
                STEP_B_STORE: w = '{1'b0, OP_STORE, EMIT_NONE, COND_NEXT, STEP_ACCEPT};
                STEP_B_INIT:  w = '{1'b0, OP_SCAN_INIT, EMIT_NONE, COND_NO_WINDOW, STEP_B_FULL};
                STEP_B_ADV:   w = '{1'b0, OP_SCAN_ADV, EMIT_NONE, COND_NEXT, STEP_ACCEPT};
                STEP_B_SCAN:  w = '{1'b0, OP_SCAN, EMIT_NONE, COND_SCAN_MORE, STEP_B_SCAN};
                STEP_B_CHK:   w = '{1'b0, OP_NONE, EMIT_NONE, COND_MATCH, STEP_B_HIT};
                STEP_B_FULL:  w = '{1'b0, OP_NONE, EMIT_NONE, COND_NOT_FULL, STEP_ACCEPT};
                STEP_B_OVF:   w = '{1'b0, OP_CLOSE, EMIT_FAIL_FULL, COND_JUMP, STEP_ACCEPT};
                STEP_B_HIT:   w = '{1'b0, OP_CLOSE, EMIT_READING, COND_JUMP, STEP_ACCEPT};
                default:      w = '{1'b0, OP_NONE, EMIT_NONE, COND_JUMP, STEP_ACCEPT};
            endcase
            return w;
        end
    endfunction

endpackage

// ===== hdl/msp_ram.sv =====
`timescale 1ns / 1ps

module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/msp_crc.sv =====
`timescale 1ns / 1ps

// One byte of the reflected CRC-16 used on the serial link.
module msp_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ msp_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== hdl/msp_seq.sv =====
`timescale 1ns / 1ps

// Step counter and control store. Steps that deliver a result hold while the
// output register is still occupied.
module msp_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  msp_pkg::flags_t flags,
    output msp_pkg::uword_t uw,
    output logic            go
);

    msp_pkg::step_t pc_reg;
    msp_pkg::step_t pc_next;
    msp_pkg::step_t disp_step;
    logic           cond_hit;

    assign uw = msp_pkg::ucode(pc_reg);
    assign go = (uw.emit == msp_pkg::EMIT_NONE) || flags.out_free;

    // Bytes and ticks only matter while a poll is running.
    always_comb begin
        if (!flags.in_valid) begin
            disp_step = msp_pkg::STEP_ACCEPT;
        end else if (flags.in_kind == msp_pkg::KIND_START) begin
            disp_step = msp_pkg::STEP_S_INIT;
        end else if (flags.in_kind == msp_pkg::KIND_BYTE && flags.active) begin
            disp_step = msp_pkg::STEP_B_STORE;
        end else if (flags.in_kind == msp_pkg::KIND_TICK && flags.active) begin
            disp_step = msp_pkg::STEP_T_INC;
        end else begin
            disp_step = msp_pkg::STEP_ACCEPT;
        end
    end

    always_comb begin
        unique case (uw.cond)
            msp_pkg::COND_NEXT:        cond_hit = 1'b0;
            msp_pkg::COND_JUMP:        cond_hit = 1'b1;
            msp_pkg::COND_DISPATCH:    cond_hit = 1'b1;
            msp_pkg::COND_REQ_MORE:    cond_hit = flags.req_more;
            msp_pkg::COND_SCAN_MORE:   cond_hit = flags.scan_more;
            msp_pkg::COND_NO_WINDOW:   cond_hit = !flags.window;
            msp_pkg::COND_MATCH:       cond_hit = flags.match;
            msp_pkg::COND_NOT_FULL:    cond_hit = !flags.full;
            msp_pkg::COND_NOT_TIMEOUT: cond_hit = !flags.timeout;
            default:                   cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            if (uw.cond == msp_pkg::COND_DISPATCH) begin
                pc_next = disp_step;
            end else if (cond_hit) begin
                pc_next = uw.target;
            end else begin
                pc_next = pc_reg + msp_pkg::step_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= msp_pkg::STEP_ACCEPT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/modbus_sensor_poll_transaction_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  ---------------------------------------
// s_        in         s_valid / s_ready     in_item_t: kind, sensor_id, rx_byte
// m_        out        m_valid / m_ready     out_item_t: result_kind, tx_byte, water_level,
//                                            temperature, fail_cause, last
// cfg_      in         cfg_valid / cfg_ready cfg_wdata: response_timeout_ms
//
// One request is taken at a time; s_ready is high only on the accept step of the
// microprogram. A start request delivers the eight request bytes; a tick advances the
// elapsed count and checks the timeout; a received byte is stored and, once a full window
// is stored, checked through 13 one-byte reads of the buffer RAM. Ignored requests end
// on the accept step. Each delivered result waits while m_ready is low.
// Reset is synchronous on aresetn, active low; it leaves no poll running and the
// timeout at 100 ms. The buffer RAM needs no clearing: only stored bytes are read.
module modbus_sensor_poll_transaction_unit #(
    parameter int BUFFER_BYTES = msp_pkg::BUFFER_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  msp_pkg::in_item_t  s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output msp_pkg::out_item_t m_data,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_wdata
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);

    // Sequencer interface
    msp_pkg::uword_t uw;
    msp_pkg::flags_t flags;
    logic            go;

    // Poll state
    logic              active_reg, active_next;
    logic [7:0]        addr_reg, addr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [15:0]       timeout_reg, timeout_next;

    // Working registers for the request and the window check
    msp_pkg::in_item_t  item_reg, item_next;
    logic [15:0]        crc_reg, crc_next;
    logic [3:0]         idx_reg, idx_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic               ok_reg, ok_next;
    logic [15:0]        level_reg, level_next;
    logic signed [15:0] temp_reg, temp_next;

    // Result register, which frees the sequencer from the consumer
    logic               m_valid_reg, m_valid_next;
    msp_pkg::out_item_t m_data_reg, m_data_next;

    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic [7:0]  req_byte;
    logic [7:0]  crc_byte;
    logic [15:0] crc_new;
    logic        out_load;

    msp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uw      (uw),
        .go      (go)
    );

    // The receive buffer is written at the fill count and read through a
    // pointer that walks the newest window.
    msp_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item_reg.rx_byte),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // A single CRC unit serves both the outgoing request and the response check.
    assign crc_byte = (uw.op == msp_pkg::OP_SCAN) ? ram_rdata : req_byte;

    msp_crc u_crc (
        .crc_in  (crc_reg),
        .data_in (crc_byte),
        .crc_out (crc_new)
    );

    // The request: address, function, start register, register count, CRC.
    always_comb begin
        case (idx_reg[2:0])
            msp_pkg::REQ_ADDR:   req_byte = addr_reg;
            msp_pkg::REQ_FUNC:   req_byte = msp_pkg::FUNC_READ_HOLDING;
            msp_pkg::REQ_REG_HI: req_byte = msp_pkg::START_REG_HI;
            msp_pkg::REQ_REG_LO: req_byte = msp_pkg::START_REG_LO;
            msp_pkg::REQ_CNT_HI: req_byte = msp_pkg::REG_COUNT_HI;
            msp_pkg::REQ_CNT_LO: req_byte = msp_pkg::REG_COUNT_LO;
            msp_pkg::REQ_CRC_LO: req_byte = crc_reg[7:0];
            msp_pkg::REQ_CRC_HI: req_byte = crc_reg[15:8];
            default:             req_byte = 8'h00;
        endcase
    end

    always_comb begin
        flags.in_valid  = s_valid;
        flags.in_kind   = s_data.kind;
        flags.active    = active_reg;
        flags.req_more  = idx_reg != 4'(msp_pkg::REQ_LEN - 1);
        flags.scan_more = idx_reg != msp_pkg::WIN_CRC_HI;
        flags.window    = count_reg >= CW'(msp_pkg::FRAME_LEN);
        flags.match     = ok_reg;
        flags.full      = count_reg >= CW'(BUFFER_BYTES);
        flags.timeout   = elapsed_reg >= timeout_reg;
        flags.out_free  = !m_valid_reg || m_ready;
    end

    assign s_ready   = uw.accept;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Datapath: each control word selects one operation, applied only when the
    // step is allowed to advance.
    always_comb begin
        active_next  = active_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        timeout_next = timeout_reg;
        item_next    = item_reg;
        crc_next     = crc_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        ok_next      = ok_reg;
        level_next   = level_reg;
        temp_next    = temp_reg;
        ram_we       = 1'b0;

        if (cfg_valid) begin
            timeout_next = cfg_wdata;
        end

        if (go) begin
            unique case (uw.op)
                msp_pkg::OP_LATCH: begin
                    if (s_valid) begin
                        item_next = s_data;
                    end
                end
                msp_pkg::OP_START: begin
                    // A start while a poll runs simply replaces it.
                    addr_next    = item_reg.sensor_id;
                    active_next  = 1'b1;
                    count_next   = '0;
                    elapsed_next = '0;
                    crc_next     = msp_pkg::CRC_INIT;
                    idx_next     = '0;
                end
                msp_pkg::OP_REQ: begin
                    // The CRC must stay put while its own two bytes go out.
                    if (idx_reg < 4'(msp_pkg::REQ_CRC_SPAN)) begin
                        crc_next = crc_new;
                    end
                    idx_next = idx_reg + 4'd1;
                end
                msp_pkg::OP_TICK: begin
                    if (elapsed_reg != msp_pkg::ELAPSED_MAX) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
                msp_pkg::OP_STORE: begin
                    if (!flags.full) begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                msp_pkg::OP_SCAN_INIT: begin
                    ptr_next = AW'(count_reg - CW'(msp_pkg::FRAME_LEN));
                    idx_next = '0;
                    crc_next = msp_pkg::CRC_INIT;
                    ok_next  = 1'b1;
                end
                msp_pkg::OP_SCAN_ADV: begin
                    ptr_next = ptr_reg + AW'(1);
                end
                msp_pkg::OP_SCAN: begin
                    ptr_next = ptr_reg + AW'(1);
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg < 4'(msp_pkg::CRC_SPAN)) begin
                        crc_next = crc_new;
                    end
                    case (idx_reg)
                        msp_pkg::WIN_ADDR: begin
                            if (ram_rdata != addr_reg) ok_next = 1'b0;
                        end
                        msp_pkg::WIN_FUNC: begin
                            if (ram_rdata != msp_pkg::FUNC_READ_HOLDING) ok_next = 1'b0;
                        end
                        msp_pkg::WIN_COUNT: begin
                            if (ram_rdata != msp_pkg::RESP_BYTE_COUNT) ok_next = 1'b0;
                        end
                        msp_pkg::WIN_LEVEL_HI: level_next[15:8] = ram_rdata;
                        msp_pkg::WIN_LEVEL_LO: level_next[7:0]  = ram_rdata;
                        msp_pkg::WIN_TEMP_HI:  temp_next[15:8]  = ram_rdata;
                        msp_pkg::WIN_TEMP_LO:  temp_next[7:0]   = ram_rdata;
                        msp_pkg::WIN_CRC_LO: begin
                            if (ram_rdata != crc_reg[7:0]) ok_next = 1'b0;
                        end
                        msp_pkg::WIN_CRC_HI: begin
                            if (ram_rdata != crc_reg[15:8]) ok_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
                msp_pkg::OP_CLOSE: begin
                    active_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Result register
    assign out_load = go && (uw.emit != msp_pkg::EMIT_NONE);

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next            = 1'b1;
            m_data_next             = '0;
            m_data_next.last        = 1'b1;
            unique case (uw.emit)
                msp_pkg::EMIT_TX: begin
                    m_data_next.result_kind = msp_pkg::RK_TX;
                    m_data_next.tx_byte     = req_byte;
                    m_data_next.last        = idx_reg == 4'(msp_pkg::REQ_LEN - 1);
                end
                msp_pkg::EMIT_READING: begin
                    m_data_next.result_kind = msp_pkg::RK_READING;
                    m_data_next.water_level = level_reg;
                    m_data_next.temperature = temp_reg;
                end
                msp_pkg::EMIT_FAIL_TIME: begin
                    m_data_next.result_kind = msp_pkg::RK_FAIL;
                    m_data_next.fail_cause  = msp_pkg::CAUSE_TIMEOUT;
                end
                msp_pkg::EMIT_FAIL_FULL: begin
                    m_data_next.result_kind = msp_pkg::RK_FAIL;
                    m_data_next.fail_cause  = msp_pkg::CAUSE_FULL;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            addr_reg    <= '0;
            count_reg   <= '0;
            elapsed_reg <= '0;
            timeout_reg <= msp_pkg::TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            addr_reg    <= addr_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            timeout_reg <= timeout_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        crc_reg    <= crc_next;
        idx_reg    <= idx_next;
        ptr_reg    <= ptr_next;
        ok_reg     <= ok_next;
        level_reg  <= level_next;
        temp_reg   <= temp_next;
        m_data_reg <= m_data_next;
    end

    // The fill count never runs past the buffer.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(BUFFER_BYTES))
        else $error("receive count beyond buffer size");

    // A result is never loaded over one the consumer has not yet taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // Readings and failures always close the results of their request.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind != msp_pkg::RK_TX) |-> m_data.last)
        else $error("reading or failure not marked last");

    // An accepted start request always leaves a poll running.
    a_start_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == msp_pkg::OP_START && go) |=> active_reg)
        else $error("poll not active after start");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // The input kind that the block leaves without a meaning.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // The longest stretch that a correct run can spend without a handshake is a
    // settling wait, a sender pause and a byte request, plus a stall of the result
    // channel. This limit is that sum taken many times over.
    localparam int QUIET_LIMIT   = 5000;
    // Cycles allowed for a request that causes no result to finish its scan.
    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_ITEMS  = 450;
    localparam int LONG_TICKS    = 20;

    typedef logic [msp_pkg::FRAME_LEN-1:0][7:0] frame_t;

    typedef enum logic [2:0] {
        SC_GOOD_REPLY,
        SC_CORRUPT_REPLY,
        SC_FOREIGN_REPLY,
        SC_FLOOD,
        SC_SILENCE,
        SC_NOISE
    } poll_scenario_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    msp_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    msp_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_wdata = '0;

    // Mirror of the poll state, advanced on every accepted request.
    logic [7:0]  mirror_rx_bytes [msp_pkg::BUFFER_BYTES];
    int unsigned mirror_rx_count = 0;
    logic [15:0] mirror_elapsed  = '0;
    bit          mirror_active   = 1'b0;
    logic [7:0]  mirror_addr     = '0;
    logic [15:0] mirror_timeout  = msp_pkg::TIMEOUT_RESET;

    msp_pkg::out_item_t poll_results_due [$];
    int unsigned applied_items  = 0;
    int unsigned mismatch_count = 0;
    bit          steady         = 1'b0;

    modbus_sensor_poll_transaction_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ msp_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic msp_pkg::out_item_t make_result(input logic [1:0] rk,
                                                       input logic [7:0] tx,
                                                       input logic [15:0] level,
                                                       input logic [15:0] temp,
                                                       input logic cause, input logic fin);
        msp_pkg::out_item_t r;
        r.result_kind = rk;
        r.tx_byte     = tx;
        r.water_level = level;
        r.temperature = temp;
        r.fail_cause  = cause;
        r.last        = fin;
        return r;
    endfunction

    // Works out what the block must deliver for one accepted request and moves
    // the mirrored state on. Reports whether the request had any effect.
    task automatic advance_poll(input msp_pkg::in_item_t it, output bit acted);
        logic [7:0]  req [msp_pkg::REQ_LEN];
        logic [15:0] crc;
        int unsigned base;
        bit          hit;
        acted = 1'b0;
        if (it.kind == msp_pkg::KIND_START) begin
            acted           = 1'b1;
            mirror_addr     = it.sensor_id;
            mirror_active   = 1'b1;
            mirror_rx_count = 0;
            mirror_elapsed  = '0;
            req[msp_pkg::REQ_ADDR]   = mirror_addr;
            req[msp_pkg::REQ_FUNC]   = msp_pkg::FUNC_READ_HOLDING;
            req[msp_pkg::REQ_REG_HI] = msp_pkg::START_REG_HI;
            req[msp_pkg::REQ_REG_LO] = msp_pkg::START_REG_LO;
            req[msp_pkg::REQ_CNT_HI] = msp_pkg::REG_COUNT_HI;
            req[msp_pkg::REQ_CNT_LO] = msp_pkg::REG_COUNT_LO;
            crc = msp_pkg::CRC_INIT;
            for (int i = 0; i < msp_pkg::REQ_CRC_SPAN; i++) begin
                crc = crc16_feed(crc, req[i]);
            end
            req[msp_pkg::REQ_CRC_LO] = crc[7:0];
            req[msp_pkg::REQ_CRC_HI] = crc[15:8];
            for (int i = 0; i < msp_pkg::REQ_LEN; i++) begin
                poll_results_due.push_back(make_result(msp_pkg::RK_TX, req[i], '0, '0,
                                                       msp_pkg::CAUSE_TIMEOUT,
                                                       i == msp_pkg::REQ_LEN - 1));
            end
        end else if (mirror_active && it.kind == msp_pkg::KIND_BYTE) begin
            acted = 1'b1;
            if (mirror_rx_count < msp_pkg::BUFFER_BYTES) begin
                mirror_rx_bytes[mirror_rx_count] = it.rx_byte;
                mirror_rx_count++;
            end
            hit  = 1'b0;
            base = 0;
            // Only the newest thirteen bytes can hold a fresh response.
            if (mirror_rx_count >= msp_pkg::FRAME_LEN) begin
                base = mirror_rx_count - msp_pkg::FRAME_LEN;
                crc  = msp_pkg::CRC_INIT;
                for (int i = 0; i < msp_pkg::CRC_SPAN; i++) begin
                    crc = crc16_feed(crc, mirror_rx_bytes[base + i]);
                end
                hit = mirror_rx_bytes[base + msp_pkg::WIN_ADDR] == mirror_addr &&
                      mirror_rx_bytes[base + msp_pkg::WIN_FUNC] ==
                          msp_pkg::FUNC_READ_HOLDING &&
                      mirror_rx_bytes[base + msp_pkg::WIN_COUNT] ==
                          msp_pkg::RESP_BYTE_COUNT &&
                      crc == {mirror_rx_bytes[base + msp_pkg::WIN_CRC_HI],
                              mirror_rx_bytes[base + msp_pkg::WIN_CRC_LO]};
            end
            if (hit) begin
                mirror_active = 1'b0;
                poll_results_due.push_back(make_result(msp_pkg::RK_READING, '0,
                    {mirror_rx_bytes[base + msp_pkg::WIN_LEVEL_HI],
                     mirror_rx_bytes[base + msp_pkg::WIN_LEVEL_LO]},
                    {mirror_rx_bytes[base + msp_pkg::WIN_TEMP_HI],
                     mirror_rx_bytes[base + msp_pkg::WIN_TEMP_LO]},
                    msp_pkg::CAUSE_TIMEOUT, 1'b1));
            end else if (mirror_rx_count >= msp_pkg::BUFFER_BYTES) begin
                mirror_active = 1'b0;
                poll_results_due.push_back(make_result(msp_pkg::RK_FAIL, '0, '0, '0,
                                                       msp_pkg::CAUSE_FULL, 1'b1));
            end
        end else if (mirror_active && it.kind == msp_pkg::KIND_TICK) begin
            acted = 1'b1;
            if (mirror_elapsed != msp_pkg::ELAPSED_MAX) begin
                mirror_elapsed++;
            end
            if (mirror_elapsed >= mirror_timeout) begin
                mirror_active = 1'b0;
                poll_results_due.push_back(make_result(msp_pkg::RK_FAIL, '0, '0, '0,
                                                       msp_pkg::CAUSE_TIMEOUT, 1'b1));
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Offers one request, with a random pause in front of it unless the run is
    // in a steady stretch. Valid stays high afterwards so that back-to-back
    // requests need no second assignment in one step.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] id,
                             input logic [7:0] data);
        msp_pkg::in_item_t it;
        bit                acted;
        int unsigned       roll;
        int unsigned       gap;
        it.kind      = kind;
        it.sensor_id = id;
        it.rx_byte   = data;
        gap = 0;
        if (!steady) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                gap = $urandom_range(1, 3);
            end else if (roll < 24) begin
                gap = $urandom_range(4, 40);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        advance_poll(it, acted);
        if (acted) begin
            applied_items++;
        end
    endtask

    // A received byte, now and then preceded by a millisecond tick.
    task automatic send_rx(input logic [7:0] b);
        if ($urandom_range(0, 99) < 8) begin
            send_item(msp_pkg::KIND_TICK, rand_byte(), rand_byte());
        end
        send_item(msp_pkg::KIND_BYTE, rand_byte(), b);
    endtask

    task automatic send_frame(input frame_t f);
        for (int i = 0; i < msp_pkg::FRAME_LEN; i++) begin
            send_rx(f[i]);
        end
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (poll_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wdata <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid      <= 1'b0;
        mirror_timeout  = value;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 16'h0000;
        if (roll < 20) return 16'hFFFF;
        if (roll < 25) return 16'h8000;
        if (roll < 30) return 16'h7FFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // A well-formed response; the unused register bytes are random.
    function automatic frame_t build_response(input logic [7:0] addr, input logic [15:0] level,
                                              input logic [15:0] temp);
        frame_t      f;
        logic [15:0] crc;
        f[msp_pkg::WIN_ADDR]     = addr;
        f[msp_pkg::WIN_FUNC]     = msp_pkg::FUNC_READ_HOLDING;
        f[msp_pkg::WIN_COUNT]    = msp_pkg::RESP_BYTE_COUNT;
        f[msp_pkg::WIN_LEVEL_HI] = level[15:8];
        f[msp_pkg::WIN_LEVEL_LO] = level[7:0];
        for (int i = msp_pkg::WIN_LEVEL_LO + 1; i < msp_pkg::WIN_TEMP_HI; i++) begin
            f[i] = rand_byte();
        end
        f[msp_pkg::WIN_TEMP_HI] = temp[15:8];
        f[msp_pkg::WIN_TEMP_LO] = temp[7:0];
        crc = msp_pkg::CRC_INIT;
        for (int i = 0; i < msp_pkg::CRC_SPAN; i++) begin
            crc = crc16_feed(crc, f[i]);
        end
        f[msp_pkg::WIN_CRC_LO] = crc[7:0];
        f[msp_pkg::WIN_CRC_HI] = crc[15:8];
        return f;
    endfunction

    task automatic test_ignored_while_idle();
        send_item(msp_pkg::KIND_BYTE, rand_byte(), rand_byte());
        send_item(msp_pkg::KIND_TICK, rand_byte(), rand_byte());
        send_item(KIND_UNUSED, rand_byte(), rand_byte());
    endtask

    task automatic test_request_and_reading();
        send_item(msp_pkg::KIND_START, 8'hFF, rand_byte());
        send_frame(build_response(8'hFF, 16'hFFFF, 16'h8000));
    endtask

    // A start while a poll runs replaces it; the unused kind leaves it alone.
    task automatic test_restart_and_unused_kind();
        send_item(msp_pkg::KIND_START, 8'h00, rand_byte());
        send_item(KIND_UNUSED, rand_byte(), rand_byte());
        send_item(msp_pkg::KIND_START, 8'h5A, rand_byte());
    endtask

    task automatic test_timeout_limits();
        write_timeout(16'd1);
        send_item(msp_pkg::KIND_TICK, rand_byte(), rand_byte());
        write_timeout(16'd0);
        send_item(msp_pkg::KIND_START, rand_byte(), rand_byte());
        send_item(msp_pkg::KIND_TICK, rand_byte(), rand_byte());
    endtask

    // The largest timeout keeps a poll open through a run of ticks.
    task automatic test_longest_timeout();
        write_timeout(16'hFFFF);
        steady = 1'b1;
        send_item(msp_pkg::KIND_START, rand_byte(), rand_byte());
        repeat (LONG_TICKS) send_item(msp_pkg::KIND_TICK, rand_byte(), rand_byte());
        steady = 1'b0;
    endtask

    task automatic test_random_polls();
        int unsigned    target;
        int unsigned    phase;
        int unsigned    roll;
        int unsigned    count;
        poll_scenario_t sc;
        frame_t         f;
        target = applied_items + RANDOM_ITEMS;
        phase  = 0;
        while (applied_items < target) begin
            if (phase % 4 == 3) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)      write_timeout(16'($urandom_range(1, 12)));
                else if (roll < 70) write_timeout(16'($urandom_range(13, 40)));
                else if (roll < 78) write_timeout(16'd0);
                else if (roll < 86) write_timeout(16'd1);
                else if (roll < 93) write_timeout(16'hFFFF);
                else                write_timeout(16'($urandom_range(0, 65535)));
            end
            // One phase runs with neither side ever idling.
            steady = (phase == 6);
            if ($urandom_range(0, 99) < 90) begin
                send_item(msp_pkg::KIND_START, rand_byte(), rand_byte());
            end
            roll = $urandom_range(0, 99);
            if (roll < 45)      sc = SC_GOOD_REPLY;
            else if (roll < 60) sc = SC_CORRUPT_REPLY;
            else if (roll < 70) sc = SC_FOREIGN_REPLY;
            else if (roll < 80) sc = SC_FLOOD;
            else if (roll < 90) sc = SC_SILENCE;
            else                sc = SC_NOISE;
            case (sc)
                SC_GOOD_REPLY: begin
                    count = ($urandom_range(0, 1) == 0) ? 0 :
                            $urandom_range(1, msp_pkg::BUFFER_BYTES - msp_pkg::FRAME_LEN);
                    repeat (count) send_rx(rand_byte());
                    send_frame(build_response(mirror_addr, pick_word(), pick_word()));
                end
                SC_CORRUPT_REPLY: begin
                    f = build_response(mirror_addr, pick_word(), pick_word());
                    roll = $urandom_range(0, msp_pkg::FRAME_LEN - 1);
                    f[roll] = f[roll] ^ (8'h01 << $urandom_range(0, 7));
                    send_frame(f);
                    if ($urandom_range(0, 1) == 1) begin
                        send_frame(build_response(mirror_addr, pick_word(), pick_word()));
                    end
                end
                SC_FOREIGN_REPLY: begin
                    send_frame(build_response(mirror_addr ^ 8'($urandom_range(1, 255)),
                                              pick_word(), pick_word()));
                    send_frame(build_response(mirror_addr, pick_word(), pick_word()));
                end
                SC_FLOOD: begin
                    repeat (msp_pkg::BUFFER_BYTES + $urandom_range(0, 3)) begin
                        send_item(msp_pkg::KIND_BYTE, rand_byte(), rand_byte());
                    end
                end
                SC_SILENCE: begin
                    count = (mirror_timeout > 43) ? 45 : mirror_timeout + 2;
                    repeat (count) begin
                        send_item(msp_pkg::KIND_TICK, rand_byte(), rand_byte());
                    end
                end
                SC_NOISE: begin
                    repeat (12) begin
                        send_item(2'($urandom_range(0, 3)), rand_byte(), rand_byte());
                    end
                end
            endcase
            // The sender holds off here until every result owed has come back.
            wait_results_drained();
            phase++;
        end
        steady = 1'b0;
    endtask

    // Each delivered result is held against the oldest one owed; the result
    // channel stalls at random except in steady stretches.
    always @(posedge aclk) begin : result_checker
        msp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (poll_results_due.size() == 0) begin
                report_mismatch($sformatf("result %h with none owed", m_data));
            end else begin
                want = poll_results_due.pop_front();
                if (m_data.result_kind !== want.result_kind)
                    report_mismatch($sformatf("result_kind %h, want %h",
                                              m_data.result_kind, want.result_kind));
                if (m_data.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %h, want %h",
                                              m_data.tx_byte, want.tx_byte));
                if (m_data.water_level !== want.water_level)
                    report_mismatch($sformatf("water_level %h, want %h",
                                              m_data.water_level, want.water_level));
                if (m_data.temperature !== want.temperature)
                    report_mismatch($sformatf("temperature %h, want %h",
                                              m_data.temperature, want.temperature));
                if (m_data.fail_cause !== want.fail_cause)
                    report_mismatch($sformatf("fail_cause %h, want %h",
                                              m_data.fail_cause, want.fail_cause));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("last %h, want %h", m_data.last, want.last));
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 24);
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ignored_while_idle();
        test_request_and_reading();
        test_restart_and_unused_kind();
        test_timeout_limits();
        test_longest_timeout();
        test_random_polls();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
